@@ rtl/mpbt_pkg.sv @@
// Package for the mouse position and button tracker: types, codes and helper functions.
package mpbt_pkg;

  // Number of physical buttons tracked (legal range 1 to 8).
  localparam int unsigned NumButtons = 4;
  // Buttons that can be addressed by an event and that appear on the result.
  localparam int unsigned NumOutButtons = 4;
  localparam int unsigned NumLanes = (NumButtons < NumOutButtons) ? NumButtons : NumOutButtons;

  localparam int unsigned CoordW = 12;
  localparam int unsigned DeltaW = 16;
  localparam int unsigned SumW   = 21;
  localparam int unsigned PhaseW = 2;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 5;
  localparam int unsigned OutRawW  = 2 * CoordW + 3 * SumW + NumOutButtons
                                     + NumOutButtons * PhaseW;
  localparam int unsigned OutDataW = ((OutRawW + 7) / 8) * 8;

  // Item operations.
  localparam logic [1:0] OpFrameStart = 2'd0;
  localparam logic [1:0] OpEvent      = 2'd1;
  localparam logic [1:0] OpSetPos     = 2'd2;

  // Event kinds.
  localparam logic [2:0] KindMoveX   = 3'd0;
  localparam logic [2:0] KindMoveY   = 3'd1;
  localparam logic [2:0] KindWheel   = 3'd2;
  localparam logic [2:0] KindButton0 = 3'd3;
  localparam logic [2:0] KindIgnored = 3'd7;

  // Button phases.
  localparam logic [PhaseW-1:0] PhIdle     = 2'd0;
  localparam logic [PhaseW-1:0] PhPressed  = 2'd1;
  localparam logic [PhaseW-1:0] PhHeld     = 2'd2;
  localparam logic [PhaseW-1:0] PhReleased = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] RegAreaLeft   = 2'd0;
  localparam logic [1:0] RegAreaTop    = 2'd1;
  localparam logic [1:0] RegAreaRight  = 2'd2;
  localparam logic [1:0] RegAreaBottom = 2'd3;

  localparam int unsigned PressBit = 7;

  typedef struct packed {
    logic [1:0]               op;
    logic [2:0]               kind;
    logic signed [DeltaW-1:0] value;
    logic signed [DeltaW-1:0] new_x;
    logic signed [DeltaW-1:0] new_y;
  } item_t;

  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
  } area_t;

  typedef struct packed {
    logic [CoordW-1:0]                        cursor_x;
    logic [CoordW-1:0]                        cursor_y;
    logic signed [SumW-1:0]                   frame_dx;
    logic signed [SumW-1:0]                   frame_dy;
    logic signed [SumW-1:0]                   frame_dz;
    logic [NumOutButtons-1:0]                 buttons_down;
    logic [NumOutButtons-1:0][PhaseW-1:0]     phase;
  } result_t;

  // Saturating add of a signed delta to a frame sum.
  function automatic logic signed [SumW-1:0] sat_add(logic signed [SumW-1:0] s,
                                                     logic signed [DeltaW-1:0] d);
    logic signed [SumW:0] r;
    logic signed [SumW:0] hi_lim;
    logic signed [SumW:0] lo_lim;
    hi_lim = (SumW+1)'((1 << (SumW - 1)) - 1);
    lo_lim = -hi_lim - (SumW+1)'(1);
    r = (SumW+1)'(s) + (SumW+1)'(d);
    if (r > hi_lim) begin
      return hi_lim[SumW-1:0];
    end else if (r < lo_lim) begin
      return lo_lim[SumW-1:0];
    end
    return r[SumW-1:0];
  endfunction

  // Clamp a signed coordinate into [lo, hi]; the low test wins first, so in an
  // inverted area a value below the low bound resolves to the low bound and any other value to the high bound.
  function automatic logic [CoordW-1:0] clamp_pos(logic signed [DeltaW+1:0] v,
                                                  logic [CoordW-1:0] lo,
                                                  logic [CoordW-1:0] hi);
    logic signed [DeltaW+1:0] lo_s;
    logic signed [DeltaW+1:0] hi_s;
    lo_s = $signed({{(DeltaW + 2 - CoordW){1'b0}}, lo});
    hi_s = $signed({{(DeltaW + 2 - CoordW){1'b0}}, hi});
    if (v < lo_s) begin
      return lo;
    end else if (v > hi_s) begin
      return hi;
    end
    return v[CoordW-1:0];
  endfunction

endpackage

@@ rtl/mpbt_in_reg.sv @@
// Input register stage of the mouse tracker: captures one item and holds it until taken.
module mpbt_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  mpbt_pkg::item_t     item_i,
  output logic                valid_o,
  input  logic                take_i,
  output mpbt_pkg::item_t     item_o
);

  logic            valid_q, valid_d;
  mpbt_pkg::item_t item_q;

  // A held item that is taken this cycle frees the stage for the next one.
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/mpbt_update.sv @@
// Tracker state registers and the combinational update applied for each item.
module mpbt_update (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  mpbt_pkg::item_t     item_i,
  input  mpbt_pkg::area_t     area_i,
  output mpbt_pkg::result_t   result_o
);

  logic [mpbt_pkg::CoordW-1:0]        pos_x_q, pos_x_d;
  logic [mpbt_pkg::CoordW-1:0]        pos_y_q, pos_y_d;
  logic signed [mpbt_pkg::SumW-1:0]   sum_dx_q, sum_dx_d;
  logic signed [mpbt_pkg::SumW-1:0]   sum_dy_q, sum_dy_d;
  logic signed [mpbt_pkg::SumW-1:0]   sum_dz_q, sum_dz_d;
  logic [mpbt_pkg::NumLanes-1:0]      held_q, held_d;
  logic [mpbt_pkg::NumLanes-1:0][mpbt_pkg::PhaseW-1:0] phase_q, phase_d;

  logic signed [mpbt_pkg::DeltaW+1:0] move_x;
  logic signed [mpbt_pkg::DeltaW+1:0] move_y;
  logic                               is_button;
  logic [2:0]                         button_idx;
  logic                               pressed;

  assign move_x = $signed({6'd0, pos_x_q}) + (mpbt_pkg::DeltaW+2)'(item_i.value);
  assign move_y = $signed({6'd0, pos_y_q}) + (mpbt_pkg::DeltaW+2)'(item_i.value);
  assign is_button = (item_i.kind >= mpbt_pkg::KindButton0)
                     && (item_i.kind != mpbt_pkg::KindIgnored);
  assign button_idx = item_i.kind - mpbt_pkg::KindButton0;
  assign pressed = item_i.value[mpbt_pkg::PressBit];

  always_comb begin
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    sum_dx_d = sum_dx_q;
    sum_dy_d = sum_dy_q;
    sum_dz_d = sum_dz_q;
    held_d   = held_q;
    phase_d  = phase_q;
    unique case (item_i.op)
      mpbt_pkg::OpFrameStart: begin
        sum_dx_d = '0;
        sum_dy_d = '0;
        sum_dz_d = '0;
        for (int i = 0; i < mpbt_pkg::NumLanes; i++) begin
          case (phase_q[i])
            mpbt_pkg::PhPressed:  phase_d[i] = mpbt_pkg::PhHeld;
            mpbt_pkg::PhHeld:     if (!held_q[i]) phase_d[i] = mpbt_pkg::PhReleased;
            mpbt_pkg::PhReleased: if (!held_q[i]) phase_d[i] = mpbt_pkg::PhIdle;
            default:              phase_d[i] = phase_q[i];
          endcase
        end
      end
      mpbt_pkg::OpEvent: begin
        if (item_i.kind == mpbt_pkg::KindMoveX) begin
          sum_dx_d = mpbt_pkg::sat_add(sum_dx_q, item_i.value);
          pos_x_d  = mpbt_pkg::clamp_pos(move_x, area_i.left, area_i.right);
        end else if (item_i.kind == mpbt_pkg::KindMoveY) begin
          sum_dy_d = mpbt_pkg::sat_add(sum_dy_q, item_i.value);
          pos_y_d  = mpbt_pkg::clamp_pos(move_y, area_i.top, area_i.bottom);
        end else if (item_i.kind == mpbt_pkg::KindWheel) begin
          sum_dz_d = mpbt_pkg::sat_add(sum_dz_q, item_i.value);
        end else if (is_button) begin
          for (int i = 0; i < mpbt_pkg::NumLanes; i++) begin
            if (button_idx == 3'(i)) begin
              held_d[i] = pressed;
              if (pressed && (phase_q[i] == mpbt_pkg::PhIdle
                              || phase_q[i] == mpbt_pkg::PhReleased)) begin
                phase_d[i] = mpbt_pkg::PhPressed;
              end
            end
          end
        end
      end
      mpbt_pkg::OpSetPos: begin
        pos_x_d = mpbt_pkg::clamp_pos((mpbt_pkg::DeltaW+2)'(item_i.new_x),
                                      area_i.left, area_i.right);
        pos_y_d = mpbt_pkg::clamp_pos((mpbt_pkg::DeltaW+2)'(item_i.new_y),
                                      area_i.top, area_i.bottom);
      end
      default: begin
        pos_x_d = pos_x_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      sum_dx_q <= '0;
      sum_dy_q <= '0;
      sum_dz_q <= '0;
      held_q   <= '0;
      phase_q  <= '0;
    end else if (step_i) begin
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      sum_dx_q <= sum_dx_d;
      sum_dy_q <= sum_dy_d;
      sum_dz_q <= sum_dz_d;
      held_q   <= held_d;
      phase_q  <= phase_d;
    end
  end

  // The result of an item is the state after its update.
  always_comb begin
    result_o.cursor_x     = pos_x_d;
    result_o.cursor_y     = pos_y_d;
    result_o.frame_dx     = sum_dx_d;
    result_o.frame_dy     = sum_dy_d;
    result_o.frame_dz     = sum_dz_d;
    result_o.buttons_down = '0;
    result_o.phase        = '0;
    for (int i = 0; i < mpbt_pkg::NumLanes; i++) begin
      result_o.buttons_down[i] = held_d[i];
      result_o.phase[i]        = phase_d[i];
    end
  end

endmodule

@@ rtl/mouse_position_button_tracker_core.sv @@
// Top level of the mouse position and button tracker: ports, area registers, result register.
//
//   Channel   Direction  Handshake                       Contents
//   s_axis    in         s_axis_tvalid_i/s_axis_tready_o one item: op, kind, deltas, position
//   m_axis    out        m_axis_tvalid_o/m_axis_tready_i one result: cursor, sums, buttons
//   cfg       in         cfg_valid_i/cfg_ready_o         area register index and value
//
// Each item gives exactly one result. An item passes an input register, then
// its whole update (saturating add, clamp, button phase step) is done
// combinationally and lands in the tracker state and the result register at
// once, so one item is accepted every cycle while the output side keeps up.
// When the output stalls, the input register holds one more item and then the
// input side stalls too. Reset clears the area, the cursor, the frame sums and
// all button state; the configuration port never stalls.
module mouse_position_button_tracker_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // s_axis_tuser_i: op [1:0], event_kind [4:2]
  // s_axis_tdata_i: event_value [15:0], new_x [31:16], new_y [47:32]
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [mpbt_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic [mpbt_pkg::InUserW-1:0]   s_axis_tuser_i,
  // m_axis_tdata_o: cursor_x [11:0], cursor_y [23:12], frame_dx [44:24],
  // frame_dy [65:45], frame_dz [86:66], buttons_down [90:87], phase_b0 [92:91],
  // phase_b1 [94:93], phase_b2 [96:95], phase_b3 [98:97], zero fill [103:99]
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [mpbt_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // Configuration: index selects left, top, right or bottom.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [mpbt_pkg::CoordW-1:0]    cfg_data_i
);

  mpbt_pkg::item_t   in_item;
  mpbt_pkg::item_t   stage_item;
  logic              stage_valid;
  logic              step;
  mpbt_pkg::area_t   area_q, area_d;
  mpbt_pkg::result_t next_result;
  mpbt_pkg::result_t result_q;
  logic              out_valid_q, out_valid_d;

  // Unpack the input item.
  assign in_item.op    = s_axis_tuser_i[1:0];
  assign in_item.kind  = s_axis_tuser_i[4:2];
  assign in_item.value = s_axis_tdata_i[15:0];
  assign in_item.new_x = s_axis_tdata_i[31:16];
  assign in_item.new_y = s_axis_tdata_i[47:32];

  // The held item is processed whenever the result register is free or is
  // being emptied in this same cycle.
  assign step = stage_valid && (!out_valid_q || m_axis_tready_i);

  mpbt_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .take_i  (step),
    .item_o  (stage_item)
  );

  mpbt_update u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (stage_item),
    .area_i   (area_q),
    .result_o (next_result)
  );

  // Area registers. Writes must happen only while the block is idle, so they never
  // race an item in flight; the user is bound to this, the block itself does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    area_d = area_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mpbt_pkg::RegAreaLeft:   area_d.left   = cfg_data_i;
        mpbt_pkg::RegAreaTop:    area_d.top    = cfg_data_i;
        mpbt_pkg::RegAreaRight:  area_d.right  = cfg_data_i;
        mpbt_pkg::RegAreaBottom: area_d.bottom = cfg_data_i;
        default:                 area_d        = area_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q <= '0;
    end else begin
      area_q <= area_d;
    end
  end

  // Result register: filled by a processed item, emptied by the consumer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= next_result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;

  // Pack the result, first field in the lowest bits.
  assign m_axis_tdata_o = {
    (mpbt_pkg::OutDataW - mpbt_pkg::OutRawW)'(0),
    result_q.phase[3],
    result_q.phase[2],
    result_q.phase[1],
    result_q.phase[0],
    result_q.buttons_down,
    result_q.frame_dz,
    result_q.frame_dy,
    result_q.frame_dx,
    result_q.cursor_y,
    result_q.cursor_x
  };

endmodule
